// ----- rtl/tmas_pkg.sv -----
// Shared types and constants for the triangle mesh area accumulator.
// Stand-alone package: no dependencies.
`timescale 1ns / 1ps

package tmas_pkg;

  // Field widths
  localparam int COORD_BITS = 16;
  localparam int SUM_BITS   = 52;

  // Derived datapath widths
  localparam int DIFF_BITS  = COORD_BITS + 1;        // signed edge component
  localparam int DMAG_BITS  = COORD_BITS;            // edge component magnitude
  localparam int CROSS_BITS = 2 * COORD_BITS + 2;    // signed cross component
  localparam int CMAG_BITS  = 2 * COORD_BITS + 1;    // cross component magnitude
  localparam int MCAND_BITS = 2 * CMAG_BITS;         // shifted multiplicand
  localparam int SQ_BITS    = 2 * CMAG_BITS + 2;     // sum of three squares
  localparam int ROOT_BITS  = SQ_BITS / 2;           // integer square root
  localparam int REM_BITS   = ROOT_BITS + 2;         // root partial remainder
  localparam int CNT_BITS   = $clog2(ROOT_BITS + 1); // bit step counter

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  // One triangle word
  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_a_z;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_b_z;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] vertex_c_z;
    logic                         last_face;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic [SUM_BITS-1:0] total_area;
    logic                area_saturated;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // Multiplier jobs: six cross-product terms, then three squares
  typedef enum logic [3:0] {
    JOB_YZ   = 4'd0,
    JOB_ZY   = 4'd1,
    JOB_ZX   = 4'd2,
    JOB_XZ   = 4'd3,
    JOB_XY   = 4'd4,
    JOB_YX   = 4'd5,
    JOB_SQ_X = 4'd6,
    JOB_SQ_Y = 4'd7,
    JOB_SQ_Z = 4'd8
  } job_t;

endpackage

// ----- rtl/triangle_mesh_area_sum.sv -----
// Triangle mesh area accumulator: bit-serial cross product, squares and root.
// Depends on tmas_pkg for word types, widths, states and multiplier jobs.
`timescale 1ns / 1ps

// Each accepted word holds one triangle; the block adds floor(|(B-A)x(C-A)|)
// to a running sum in units of 2^-1 (half the cross length is the area).
// On a word with last_face set it sends the sum and its saturation flag and
// clears both. Each triangle runs six cross-product terms and three
// squares through one shared shift-and-add multiplier that consumes one
// multiplier bit per cycle, then a square root at two radicand bits per
// step, between an accept state and a finish state. The input is stalled
// while a triangle is in work; a last face waits in the finish state while
// the previous result is still held at the output.
module triangle_mesh_area_sum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tmas_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tmas_pkg::out_item_t out_item
);
  import tmas_pkg::*;

  // Signed edge component, one bit wider than a coordinate
  function automatic logic signed [DIFF_BITS-1:0] edge_diff(
    input logic signed [COORD_BITS-1:0] tip,
    input logic signed [COORD_BITS-1:0] base
  );
    logic signed [DIFF_BITS-1:0] t;
    logic signed [DIFF_BITS-1:0] b;
    t = DIFF_BITS'(tip);
    b = DIFF_BITS'(base);
    return t - b;
  endfunction

  function automatic logic [DMAG_BITS-1:0] edge_mag(input logic signed [DIFF_BITS-1:0] d);
    logic signed [DIFF_BITS-1:0] n;
    n = -d;
    return d[DIFF_BITS-1] ? n[DMAG_BITS-1:0] : d[DMAG_BITS-1:0];
  endfunction

  state_t                 state_r;
  job_t                   job_r;
  logic                   load_r;
  logic [CNT_BITS-1:0]    bit_cnt_r;
  logic                   last_r;

  // Edge magnitudes and signs
  logic [DMAG_BITS-1:0]   e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic                   e1x_neg_r, e1y_neg_r, e1z_neg_r, e2x_neg_r, e2y_neg_r, e2z_neg_r;

  // Multiplier
  logic [MCAND_BITS-1:0]  mcand_r;
  logic [CMAG_BITS-1:0]   mplier_r;
  logic                   term_neg_r;
  logic [CROSS_BITS-1:0]  cross_r;
  logic [CMAG_BITS-1:0]   cmag_x_r, cmag_y_r, cmag_z_r;
  logic [SQ_BITS-1:0]     sq_r;

  // Square root
  logic [SQ_BITS-1:0]     rad_r;
  logic [REM_BITS-1:0]    rem_r;
  logic [ROOT_BITS-1:0]   root_r;

  // Accumulator and output word
  logic [SUM_BITS-1:0]    acc_r;
  logic                   ovf_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic [CMAG_BITS-1:0]   op_a;
  logic [CMAG_BITS-1:0]   op_b;
  logic                   op_neg;
  logic                   is_sq;
  logic                   last_bit;
  logic [MCAND_BITS-1:0]  addend;
  logic [CROSS_BITS-1:0]  cross_nxt;
  logic [CROSS_BITS-1:0]  cross_neg;
  logic [CMAG_BITS-1:0]   cross_abs;
  logic [SQ_BITS-1:0]     sq_nxt;
  logic [REM_BITS+1:0]    rem_sh;
  logic [REM_BITS+1:0]    trial;
  logic [REM_BITS+1:0]    rem_sub;
  logic                   root_bit;
  logic [SUM_BITS:0]      sum_ext;
  logic                   sum_carry;
  logic [SUM_BITS-1:0]    sum_sat;
  logic                   out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Pick the operands and sign of the current multiplier job
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    case (job_r)
      JOB_YZ: begin
        op_a   = CMAG_BITS'(e1y_r);
        op_b   = CMAG_BITS'(e2z_r);
        op_neg = e1y_neg_r ^ e2z_neg_r;
      end
      JOB_ZY: begin
        op_a   = CMAG_BITS'(e1z_r);
        op_b   = CMAG_BITS'(e2y_r);
        op_neg = ~(e1z_neg_r ^ e2y_neg_r);
      end
      JOB_ZX: begin
        op_a   = CMAG_BITS'(e1z_r);
        op_b   = CMAG_BITS'(e2x_r);
        op_neg = e1z_neg_r ^ e2x_neg_r;
      end
      JOB_XZ: begin
        op_a   = CMAG_BITS'(e1x_r);
        op_b   = CMAG_BITS'(e2z_r);
        op_neg = ~(e1x_neg_r ^ e2z_neg_r);
      end
      JOB_XY: begin
        op_a   = CMAG_BITS'(e1x_r);
        op_b   = CMAG_BITS'(e2y_r);
        op_neg = e1x_neg_r ^ e2y_neg_r;
      end
      JOB_YX: begin
        op_a   = CMAG_BITS'(e1y_r);
        op_b   = CMAG_BITS'(e2x_r);
        op_neg = ~(e1y_neg_r ^ e2x_neg_r);
      end
      JOB_SQ_X: begin
        op_a = cmag_x_r;
        op_b = cmag_x_r;
      end
      JOB_SQ_Y: begin
        op_a = cmag_y_r;
        op_b = cmag_y_r;
      end
      JOB_SQ_Z: begin
        op_a = cmag_z_r;
        op_b = cmag_z_r;
      end
      default: begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
      end
    endcase
  end

  // One shift-and-add step of the shared multiplier
  always_comb begin
    is_sq     = (job_r == JOB_SQ_X) || (job_r == JOB_SQ_Y) || (job_r == JOB_SQ_Z);
    last_bit  = is_sq ? (bit_cnt_r == CNT_BITS'(CMAG_BITS - 1))
                      : (bit_cnt_r == CNT_BITS'(DMAG_BITS - 1));
    addend    = mplier_r[0] ? mcand_r : '0;
    cross_nxt = term_neg_r ? (cross_r - addend[CROSS_BITS-1:0])
                           : (cross_r + addend[CROSS_BITS-1:0]);
    cross_neg = -cross_nxt;
    cross_abs = cross_nxt[CROSS_BITS-1] ? cross_neg[CMAG_BITS-1:0]
                                        : cross_nxt[CMAG_BITS-1:0];
    sq_nxt    = sq_r + SQ_BITS'(addend);
  end

  // One restoring square-root step, two radicand bits at a time
  always_comb begin
    rem_sh   = {rem_r, rad_r[SQ_BITS-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    rem_sub  = rem_sh - trial;
    root_bit = (rem_sh >= trial);
  end

  // Add the triangle to the running sum, clamp at full scale
  always_comb begin
    sum_ext   = {1'b0, acc_r} + (SUM_BITS + 1)'(root_r);
    sum_carry = sum_ext[SUM_BITS];
    sum_sat   = sum_carry ? SUM_MAX : sum_ext[SUM_BITS-1:0];
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
    end else begin
      // drop the result word once taken, unless a new one replaces it
      if (out_valid_r && !out_stall && !((state_r == ST_DONE) && last_r)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            e1x_r     <= edge_mag(edge_diff(in_item.vertex_b_x, in_item.vertex_a_x));
            e1y_r     <= edge_mag(edge_diff(in_item.vertex_b_y, in_item.vertex_a_y));
            e1z_r     <= edge_mag(edge_diff(in_item.vertex_b_z, in_item.vertex_a_z));
            e2x_r     <= edge_mag(edge_diff(in_item.vertex_c_x, in_item.vertex_a_x));
            e2y_r     <= edge_mag(edge_diff(in_item.vertex_c_y, in_item.vertex_a_y));
            e2z_r     <= edge_mag(edge_diff(in_item.vertex_c_z, in_item.vertex_a_z));
            e1x_neg_r <= edge_diff(in_item.vertex_b_x, in_item.vertex_a_x) < 0;
            e1y_neg_r <= edge_diff(in_item.vertex_b_y, in_item.vertex_a_y) < 0;
            e1z_neg_r <= edge_diff(in_item.vertex_b_z, in_item.vertex_a_z) < 0;
            e2x_neg_r <= edge_diff(in_item.vertex_c_x, in_item.vertex_a_x) < 0;
            e2y_neg_r <= edge_diff(in_item.vertex_c_y, in_item.vertex_a_y) < 0;
            e2z_neg_r <= edge_diff(in_item.vertex_c_z, in_item.vertex_a_z) < 0;
            last_r    <= in_item.last_face;
            job_r     <= JOB_YZ;
            load_r    <= 1'b1;
            cross_r   <= '0;
            sq_r      <= '0;
            state_r   <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (load_r) begin
            // load operands of the next job
            mcand_r    <= MCAND_BITS'(op_a);
            mplier_r   <= op_b;
            term_neg_r <= op_neg;
            bit_cnt_r  <= '0;
            load_r     <= 1'b0;
          end else begin
            // advance one multiplier bit
            mcand_r   <= mcand_r << 1;
            mplier_r  <= mplier_r >> 1;
            bit_cnt_r <= last_bit ? '0 : bit_cnt_r + 1'b1;
            if (is_sq) begin
              sq_r <= sq_nxt;
            end else if (last_bit && ((job_r == JOB_ZY) || (job_r == JOB_XZ) ||
                                      (job_r == JOB_YX))) begin
              // clear after the second term of a component
              cross_r <= '0;
            end else begin
              cross_r <= cross_nxt;
            end
            if (last_bit) begin
              load_r <= 1'b1;
              job_r  <= job_t'(job_r + 4'd1);
              // close a cross component after its second term
              if (job_r == JOB_ZY) begin
                cmag_x_r <= cross_abs;
              end
              if (job_r == JOB_XZ) begin
                cmag_y_r <= cross_abs;
              end
              if (job_r == JOB_YX) begin
                cmag_z_r <= cross_abs;
              end
              if (job_r == JOB_SQ_Z) begin
                rad_r     <= sq_nxt;
                rem_r     <= '0;
                root_r    <= '0;
                state_r   <= ST_ROOT;
              end
            end
          end
        end
        ST_ROOT: begin
          rad_r     <= rad_r << 2;
          rem_r     <= root_bit ? rem_sub[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
          root_r    <= {root_r[ROOT_BITS-2:0], root_bit};
          bit_cnt_r <= bit_cnt_r + 1'b1;
          if (bit_cnt_r == CNT_BITS'(ROOT_BITS - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!last_r) begin
            acc_r   <= sum_sat;
            ovf_r   <= ovf_r | sum_carry;
            state_r <= ST_IDLE;
          end else if (out_free) begin
            // send the mesh total and clear for the next mesh
            out_item_r.total_area     <= sum_sat;
            out_item_r.area_saturated <= ovf_r | sum_carry;
            out_valid_r               <= 1'b1;
            acc_r                     <= '0;
            ovf_r                     <= 1'b0;
            state_r                   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A saturated sum stays pinned at full scale
  a_sat_pinned: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (acc_r == SUM_MAX))
    else $error("saturation flag set with sum below full scale");

  // A new result leaves the accumulator cleared
  a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ((acc_r == '0) && !ovf_r))
    else $error("accumulator not cleared after result");

  // Root remainder never exceeds twice the partial root
  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT) |-> (rem_r <= {1'b0, root_r, 1'b0}))
    else $error("square root remainder out of range");

  // An accepted triangle starts the multiplier with an operand load
  a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ((state_r == ST_MUL) && load_r && (job_r == JOB_YZ)))
    else $error("accepted triangle did not start the multiplier");

endmodule

// ----- verif/tb_triangle_mesh_area_sum.sv -----
// Self-checking testbench for triangle_mesh_area_sum: directed and random triangle meshes.
// Depends on tmas_pkg for word types, widths and the sum limit.
`timescale 1ns / 1ps

module tb_triangle_mesh_area_sum;
  import tmas_pkg::*;

  // Coordinate flavors for random triangles
  typedef enum int {
    CO_FULL,
    CO_NEAR,
    CO_EDGE
  } coord_mode_t;

  // Tracks the running mesh area and the totals still owed by the block
  class area_scoreboard;
    logic [SUM_BITS-1:0] area_sum;
    logic                clamped;
    out_item_t           expected_totals[$];
    int                  mismatches;

    function new();
      area_sum   = '0;
      clamped    = 1'b0;
      mismatches = 0;
    endfunction

    // floor(|(B-A) x (C-A)|), exact in integer arithmetic
    function logic [47:0] cross_length(in_item_t w);
      longint       ax, ay, az, ux, uy, uz, vx, vy, vz, cx, cy, cz;
      logic [127:0] sq, cand;
      logic [47:0]  root;
      int           b;
      ax = $signed(w.vertex_a_x);
      ay = $signed(w.vertex_a_y);
      az = $signed(w.vertex_a_z);
      ux = longint'($signed(w.vertex_b_x)) - ax;
      uy = longint'($signed(w.vertex_b_y)) - ay;
      uz = longint'($signed(w.vertex_b_z)) - az;
      vx = longint'($signed(w.vertex_c_x)) - ax;
      vy = longint'($signed(w.vertex_c_y)) - ay;
      vz = longint'($signed(w.vertex_c_z)) - az;
      cx = uy * vz - uz * vy;
      cy = uz * vx - ux * vz;
      cz = ux * vy - uy * vx;
      if (cx < 0) cx = -cx;
      if (cy < 0) cy = -cy;
      if (cz < 0) cz = -cz;
      sq = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
      // Build the root one bit at a time, highest first
      root = '0;
      for (b = 47; b >= 0; b--) begin
        cand = {80'd0, root} | (128'd1 << b);
        if (cand * cand <= sq) root = cand[47:0];
      end
      return root;
    endfunction

    // Fold one accepted triangle into the sum; queue a total on the last face
    function void note_triangle(in_item_t w);
      logic [47:0] len;
      out_item_t   r;
      len = cross_length(w);
      if ({{(SUM_BITS-48){1'b0}}, len} > SUM_MAX - area_sum) begin
        area_sum = SUM_MAX;
        clamped  = 1'b1;
      end else begin
        area_sum = area_sum + len;
      end
      if (w.last_face) begin
        r.total_area     = area_sum;
        r.area_saturated = clamped;
        expected_totals.push_back(r);
        area_sum = '0;
        clamped  = 1'b0;
      end
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    // Compare one accepted result word against the oldest owed total
    function void check_total(out_item_t got);
      out_item_t want;
      if (expected_totals.size() == 0) begin
        flag("result with none pending", 0, got.total_area);
        return;
      end
      want = expected_totals.pop_front();
      if (got.total_area !== want.total_area)
        flag("total_area", want.total_area, got.total_area);
      if (got.area_saturated !== want.area_saturated)
        flag("area_saturated", want.area_saturated, got.area_saturated);
    endfunction

    function int pending();
      return expected_totals.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  area_scoreboard areas;
  int             tx_idle_pct;
  int             rx_stall_pct;
  int             hold_seq;

  triangle_mesh_area_sum dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one word after a random idle gap and hold it until accepted
  task automatic drive_face(input in_item_t w);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    do @(posedge clk); while (in_stall);
    areas.note_triangle(w);
  endtask

  function automatic in_item_t mk_face(int ax, int ay, int az, int bx, int by, int bz,
                                       int cx, int cy, int cz, bit last);
    in_item_t w;
    w = {16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz),
         16'(cx), 16'(cy), 16'(cz), last};
    return w;
  endfunction

  function automatic logic [15:0] rand_coord(coord_mode_t m);
    case (m)
      CO_FULL: return 16'($urandom);
      CO_NEAR: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // Random triangle: mostly full range, some local, some at the corners
  function automatic in_item_t make_triangle(bit last);
    logic [15:0] c[9];
    int          pick;
    int          i;
    coord_mode_t m;
    pick = $urandom_range(0, 9);
    m = (pick < 5) ? CO_FULL : (pick < 8) ? CO_NEAR : CO_EDGE;
    for (i = 0; i < 9; i++)
      c[i] = rand_coord(pick == 9 ? coord_mode_t'($urandom_range(0, 2)) : m);
    // Collapse a vertex now and then for a zero-area face
    if ($urandom_range(0, 11) == 0) begin
      for (i = 0; i < 3; i++) begin
        if (pick[0]) c[6+i] = c[3+i];
        else         c[3+i] = c[i];
      end
    end
    return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], last};
  endfunction

  // Stimulus: reset, directed faces, then four idling phases of random meshes
  initial begin
    int tx_pcts[4];
    int rx_pcts[4];
    int phase;
    int sent;
    int faces;
    int k;
    tx_pcts = '{0, 54, 0, 26};
    rx_pcts = '{0, 0, 54, 26};
    areas = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_seq = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero face, a known area, corner triangles, collinear and patterned vertices
    drive_face(mk_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    drive_face(mk_face(0, 0, 0, 256, 0, 0, 0, 256, 0, 1'b1));
    drive_face(mk_face(-32768, -32768, -32768, 32767, -32768, -32768,
                       -32768, 32767, -32768, 1'b0));
    drive_face(mk_face(32767, 32767, 32767, -32768, 32767, 32767,
                       32767, 32767, -32768, 1'b0));
    drive_face(mk_face(-32768, 32767, -32768, 32767, -32768, 32767,
                       32767, 32767, -32768, 1'b1));
    drive_face(mk_face(0, 0, 0, 100, 200, 300, 200, 400, 600, 1'b1));
    drive_face(mk_face(-1, -1, -1, -32768, -32768, -32768, -1, -32768, -1, 1'b1));
    drive_face(mk_face('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA,
                       'h5555, 'h5555, 'hAAAA, 1'b0));
    drive_face(mk_face('h5555, 'hAAAA, 'h5555, 'h5555, 'h5555, 'hAAAA,
                       'hAAAA, 'h5555, 'hAAAA, 1'b1));
    drive_face(mk_face(0, 0, 0, 256, 0, 0, 0, 0, 256, 1'b0));
    drive_face(mk_face(256, 0, 0, 0, 256, 0, 0, 0, 256, 1'b0));
    drive_face(mk_face(0, 0, 0, 0, 256, 0, 256, 0, 0, 1'b1));
    drive_face(mk_face(32767, 0, -32768, -32768, 32767, 0, 0, -32768, 32767, 1'b1));
    drive_face(mk_face(1, 2, 3, 4, 5, 6, 7, 8, 10, 1'b1));

    for (phase = 0; phase < 4; phase++) begin
      tx_idle_pct = tx_pcts[phase];
      rx_stall_pct <= rx_pcts[phase];
      // Hold off the receiver for a long stretch while words keep coming
      if (phase == 0) hold_seq <= hold_seq + 1;
      sent = 0;
      while (sent < 285) begin
        faces = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
        for (k = 0; k < faces; k++) begin
          drive_face(make_triangle(k == faces - 1));
          sent++;
        end
      end
    end

    // Drain: wait for every owed total, then idle before the final check
    in_valid <= 1'b0;
    while (areas.pending() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (areas.mismatches == 0 && areas.pending() == 0) begin
      $display("[triangle_mesh_area_sum] OK");
    end else begin
      $display("[triangle_mesh_area_sum] ERROR");
    end
    $finish;
  end

  // Receiver: check accepted results, stall at random or for a long hold
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) areas.check_total(out_item);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    #15000000;
    $display("[triangle_mesh_area_sum] ERROR");
    $finish;
  end

endmodule
